@@ rtl/assert_macros.svh @@
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Hold expr true at every clock edge outside reset.
`define HSR_ASSERT_ALWAYS(lbl, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (expr)) else $error(msg);

// Hold cons true at every clock edge where ante is true, outside reset.
`define HSR_ASSERT_IMPLY(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

`endif

@@ rtl/hsr_pkg.sv @@
// Constants, widths and table functions of the slant range datapath.
package hsr_pkg;

	localparam int CORDIC_STAGES_DEF = 32;

	localparam int ANG_W  = 34;
	localparam int XY_W   = 34;
	localparam int Z_W    = 64;
	localparam int TRIG_W = 32;
	localparam int MAG_W  = 31;

	// One full turn in 2^-24 degree units and its fractions.
	localparam logic signed [ANG_W-1:0] TURN   = 34'sd6039797760;
	localparam logic signed [ANG_W-1:0] HALF_T = 34'sd3019898880;
	localparam logic signed [ANG_W-1:0] QTR_T  = 34'sd1509949440;

	localparam logic signed [XY_W-1:0] GAIN_Q30  = 34'sd652032874;
	localparam logic signed [XY_W-1:0] ONE30_XY  = 34'sd1073741824;
	localparam logic [60:0]            ONE60     = 61'h1000_0000_0000_0000;
	localparam logic [31:0]            RANGE_K   = 32'd3261952000;
	localparam logic [32:0]            SLANT_MAX = 33'h1_FFFF_FFFF;

	// Restoring long division, used only for building constants.
	function automatic logic [63:0] udiv(input logic [63:0] n, input logic [63:0] d);
		logic [63:0] q;
		logic [63:0] r;
		q = '0;
		r = '0;
		for (int i = 63; i >= 0; i--) begin
			r = {r[62:0], n[i]};
			if (r >= d) begin
				r = r - d;
				q[i] = 1'b1;
			end
		end
		return q;
	endfunction

	// Alternating arctangent series with truncating division.
	function automatic logic [63:0] atan_series(input logic [63:0] p, input logic [63:0] d2);
		logic [63:0] s;
		logic [63:0] t;
		logic [63:0] pp;
		s  = '0;
		pp = p;
		for (int k = 0; k < 64; k++) begin
			if (pp != 64'd0) begin
				t = udiv(pp, 64'(2 * k + 1));
				if ((k & 1) == 0)
					s = s + t;
				else
					s = s - t;
				pp = udiv(pp, d2);
			end
		end
		return s;
	endfunction

	// atan(2^-i) in radians Q60; entry 0 is atan(1/2)+atan(1/3).
	function automatic logic [63:0] atan_entry(input int i);
		logic [63:0] one;
		one = 64'd1 << 60;
		if (i == 0)
			return atan_series(one >> 1, 64'd4) + atan_series(udiv(one, 64'd3), 64'd9);
		else if (i <= 20)
			return atan_series(one >> i, 64'd1 << (2 * i));
		else
			return one >> i;
	endfunction

	localparam logic [63:0] PI_Q60   = 64'd4 * atan_entry(0);
	localparam logic [63:0] DEG_STEP = PI_Q60 / 64'd180;
	localparam logic [26:0] DEG_HI   = DEG_STEP[54:28];
	localparam logic [27:0] DEG_LO   = DEG_STEP[27:0];
	localparam logic [63:0] HALF_PI  = PI_Q60 / 64'd2;

endpackage

@@ rtl/hsr_sincos.sv @@
// Pipelined rotation CORDIC: angle reduction, radian scaling, sine and cosine.
module hsr_sincos #(
	parameter int STAGES = hsr_pkg::CORDIC_STAGES_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                vld_in,
	input  logic signed [hsr_pkg::ANG_W-1:0]    ang,
	output logic                                vld_out,
	output logic signed [hsr_pkg::TRIG_W-1:0]   cos_o,
	output logic signed [hsr_pkg::TRIG_W-1:0]   sin_o
);

	logic signed [hsr_pkg::ANG_W-1:0] red;
	logic signed [hsr_pkg::ANG_W-1:0] fold;
	logic signed [hsr_pkg::ANG_W-1:0] fold_abs;
	logic                             flip;

	logic [hsr_pkg::MAG_W-1:0] mag_s1;
	logic                      neg_s1, flip_s1, v_s1;
	logic [57:0]               ph_s2;
	logic [58:0]               pl_s2;
	logic                      neg_s2, flip_s2, v_s2;
	logic [85:0]               zsum;
	logic [hsr_pkg::Z_W-1:0]   zmag;

	logic signed [hsr_pkg::XY_W-1:0] cx_s [0:STAGES];
	logic signed [hsr_pkg::XY_W-1:0] cy_s [0:STAGES];
	logic signed [hsr_pkg::Z_W-1:0]  cz_s [0:STAGES];
	logic                            cf_s [0:STAGES];
	logic                            cv_s [0:STAGES];

	logic signed [hsr_pkg::XY_W-1:0] xc;
	logic signed [hsr_pkg::XY_W-1:0] yc;

	// Reduce into one turn, then fold into the right half plane.
	always_comb begin
		if (ang < -hsr_pkg::HALF_T)
			red = ang + hsr_pkg::TURN;
		else if (ang >= hsr_pkg::HALF_T)
			red = ang - hsr_pkg::TURN;
		else
			red = ang;
		flip = 1'b0;
		fold = red;
		if (red > hsr_pkg::QTR_T) begin
			fold = hsr_pkg::HALF_T - red;
			flip = 1'b1;
		end else if (red < -hsr_pkg::QTR_T) begin
			fold = -hsr_pkg::HALF_T - red;
			flip = 1'b1;
		end
		fold_abs = (fold < 0) ? -fold : fold;
	end

	always_ff @(posedge clk) begin
		mag_s1  <= fold_abs[hsr_pkg::MAG_W-1:0];
		neg_s1  <= fold[hsr_pkg::ANG_W-1];
		flip_s1 <= flip;
		ph_s2   <= 58'(mag_s1) * 58'(hsr_pkg::DEG_HI);
		pl_s2   <= 59'(mag_s1) * 59'(hsr_pkg::DEG_LO);
		neg_s2  <= neg_s1;
		flip_s2 <= flip_s1;
	end

	assign zsum = {ph_s2, 28'd0} + 86'(pl_s2);
	assign zmag = hsr_pkg::Z_W'(zsum >> 24);

	always_ff @(posedge clk) begin
		cx_s[0] <= hsr_pkg::GAIN_Q30;
		cy_s[0] <= '0;
		cz_s[0] <= neg_s2 ? -$signed(zmag) : $signed(zmag);
		cf_s[0] <= flip_s2;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1    <= 1'b0;
			v_s2    <= 1'b0;
			cv_s[0] <= 1'b0;
		end else begin
			v_s1    <= vld_in;
			v_s2    <= v_s1;
			cv_s[0] <= v_s2;
		end
	end

	for (genvar k = 0; k < STAGES; k++) begin : g_iter
		localparam logic signed [hsr_pkg::Z_W-1:0] ATAN_K = hsr_pkg::atan_entry(k);
		logic signed [hsr_pkg::XY_W-1:0] dx;
		logic signed [hsr_pkg::XY_W-1:0] dy;
		assign dx = cy_s[k] >>> k;
		assign dy = cx_s[k] >>> k;
		always_ff @(posedge clk) begin
			if (cz_s[k] >= 0) begin
				cx_s[k+1] <= cx_s[k] - dx;
				cy_s[k+1] <= cy_s[k] + dy;
				cz_s[k+1] <= cz_s[k] - ATAN_K;
			end else begin
				cx_s[k+1] <= cx_s[k] + dx;
				cy_s[k+1] <= cy_s[k] - dy;
				cz_s[k+1] <= cz_s[k] + ATAN_K;
			end
			cf_s[k+1] <= cf_s[k];
		end
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				cv_s[k+1] <= 1'b0;
			else
				cv_s[k+1] <= cv_s[k];
		end
	end

	// Clamp to the unit range, put the cosine sign back.
	always_comb begin
		if (cx_s[STAGES] < 0)
			xc = '0;
		else if (cx_s[STAGES] > hsr_pkg::ONE30_XY)
			xc = hsr_pkg::ONE30_XY;
		else
			xc = cx_s[STAGES];
		if (cy_s[STAGES] < -hsr_pkg::ONE30_XY)
			yc = -hsr_pkg::ONE30_XY;
		else if (cy_s[STAGES] > hsr_pkg::ONE30_XY)
			yc = hsr_pkg::ONE30_XY;
		else
			yc = cy_s[STAGES];
	end

	always_ff @(posedge clk) begin
		cos_o <= hsr_pkg::TRIG_W'(cf_s[STAGES] ? -xc : xc);
		sin_o <= hsr_pkg::TRIG_W'(yc);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_out <= 1'b0;
		else
			vld_out <= cv_s[STAGES];
	end

endmodule

@@ rtl/hsr_isqrt.sv @@
// Pipelined integer square root, one result bit per stage.
module hsr_isqrt #(
	parameter int IN_W  = 61,
	parameter int OUT_W = 31
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             vld_in,
	input  logic [IN_W-1:0]  rad,
	output logic             vld_out,
	output logic [OUT_W-1:0] root
);

	localparam int W = ((IN_W > 2 * OUT_W) ? IN_W : 2 * OUT_W) + 1;

	logic [W-1:0]     rem_s [0:OUT_W];
	logic [OUT_W-1:0] rt_s  [0:OUT_W];
	logic             v_s   [0:OUT_W];

	always_ff @(posedge clk) begin
		rem_s[0] <= W'(rad);
		rt_s[0]  <= '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s[0] <= 1'b0;
		else
			v_s[0] <= vld_in;
	end

	for (genvar j = 0; j < OUT_W; j++) begin : g_bit
		localparam int B = OUT_W - 1 - j;
		logic [W-1:0] trial;
		// (root + 2^B)^2 - root^2
		assign trial = (W'(rt_s[j]) << (B + 1)) + (W'(1) << (2 * B));
		always_ff @(posedge clk) begin
			if (trial <= rem_s[j]) begin
				rem_s[j+1] <= rem_s[j] - trial;
				rt_s[j+1]  <= rt_s[j] | (OUT_W'(1) << B);
			end else begin
				rem_s[j+1] <= rem_s[j];
				rt_s[j+1]  <= rt_s[j];
			end
		end
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				v_s[j+1] <= 1'b0;
			else
				v_s[j+1] <= v_s[j];
		end
	end

	assign root    = rt_s[OUT_W];
	assign vld_out = v_s[OUT_W];

endmodule

@@ rtl/haversine_slant_range.sv @@
// Top level: haversine ground distance plus altitude into a 3-D slant range.
//
// Usage
//   Input channel: drive the six position fields and raise start; a word is
//   taken at every rising edge with start high and busy low. busy stays low,
//   so a new word may enter on every clock.
//   Result channel: done pulses for one cycle with slant_range and in_range
//   valid in that same cycle. There is no back-pressure; capture on done.
//   Configuration: raise cfg_we with cfg_wdata to load max_range. Write only
//   while no word is in flight.
// Timing
//   One word per clock sustained. done is set by the path through the two
//   CORDIC pipelines and the two bit-per-stage square root pipelines.
// Reset
//   arst_n clears all valid bits and max_range; words in flight are dropped.
module haversine_slant_range #(
	parameter int CORDIC_STAGES = hsr_pkg::CORDIC_STAGES_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic signed [30:0] src_lat,
	input  logic signed [31:0] src_lon,
	input  logic signed [31:0] src_alt,
	input  logic signed [30:0] dst_lat,
	input  logic signed [31:0] dst_lon,
	input  logic signed [31:0] dst_alt,
	input  logic               cfg_we,
	input  logic [32:0]        cfg_wdata,
	output logic               done,
	output logic [32:0]        slant_range,
	output logic               in_range
);

	localparam int SC_LAT    = CORDIC_STAGES + 4;
	localparam int HG_BITS   = 31;
	localparam int HG_LAT    = HG_BITS + 1;
	localparam int SL_BITS   = 34;
	// Altitude difference is picked up beside the ground distance register.
	localparam int ADIFF_IDX = SC_LAT + 5 + HG_LAT + 1 + CORDIC_STAGES + 3;

	logic [32:0] max_range_q;

	// Stage 1: doubled latitudes, angle differences and altitude difference.
	logic signed [hsr_pkg::ANG_W-1:0] ang1_s1, ang2_s1, ang3_s1, ang4_s1;
	logic                             v_s1;
	logic signed [32:0]               dalt;
	logic [32:0]                      adiff_d [0:ADIFF_IDX];

	logic                              sc_v;
	logic signed [hsr_pkg::TRIG_W-1:0] c1, c2, sd, sl;

	logic [30:0] c1m, c2m, sdm, slm;
	logic [61:0] pfull;
	logic [30:0] pq_s2, slm_s2, slm_s3;
	logic [60:0] s1sq_s2, s1sq_s3, s1sq_s4, s1sq_s5;
	logic        pneg_s2, pneg_s3, pneg_s4, pneg_s5;
	logic        v_s2, v_s3, v_s4, v_s5, v_s6;
	logic [60:0] u_s3;
	logic [60:0] uh_s4;
	logic [61:0] ul_s4;
	logic [92:0] tsum;
	logic [60:0] t_s5;
	logic [61:0] apos;
	logic [60:0] anext;
	logic [60:0] a_s6;

	logic        h_v, g_v;
	logic [HG_BITS-1:0] h_root, g_root;

	logic signed [hsr_pkg::XY_W-1:0] vx_s [0:CORDIC_STAGES];
	logic signed [hsr_pkg::XY_W-1:0] vy_s [0:CORDIC_STAGES];
	logic signed [hsr_pkg::Z_W-1:0]  vz_s [0:CORDIC_STAGES];
	logic                            vv_s [0:CORDIC_STAGES];

	logic [60:0] zc;
	logic [60:0] zc_s8;
	logic        v_s8, v_s9, v_s10, v_s11, v_s12;
	logic [62:0] gh_s9;
	logic [61:0] gl_s9;
	logic [92:0] gsum;
	logic [32:0] ground_s10;
	logic [65:0] gsq_s11, asq_s11;
	logic [66:0] ssum_s12;

	logic              sl_v;
	logic [SL_BITS-1:0] sl_root;
	logic [32:0]       slant_sat;

	assign busy = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			max_range_q <= '0;
		else if (cfg_we)
			max_range_q <= cfg_wdata;
	end

	assign dalt = 33'(dst_alt) - 33'(src_alt);

	always_ff @(posedge clk) begin
		ang1_s1    <= hsr_pkg::ANG_W'(src_lat) <<< 1;
		ang2_s1    <= hsr_pkg::ANG_W'(dst_lat) <<< 1;
		ang3_s1    <= hsr_pkg::ANG_W'(dst_lat) - hsr_pkg::ANG_W'(src_lat);
		ang4_s1    <= hsr_pkg::ANG_W'(dst_lon) - hsr_pkg::ANG_W'(src_lon);
		adiff_d[0] <= (dalt < 0) ? 33'(-dalt) : 33'(dalt);
		// Carry the altitude difference down beside the angle pipelines.
		for (int k = 1; k <= ADIFF_IDX; k++)
			adiff_d[k] <= adiff_d[k-1];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s1 <= 1'b0;
		else
			v_s1 <= start & ~busy;
	end

	// Four matched sine/cosine pipelines; the first one carries the valid bit.
	hsr_sincos #(.STAGES(CORDIC_STAGES)) u_sc_lat1 (
		.clk(clk), .arst_n(arst_n), .vld_in(v_s1), .ang(ang1_s1),
		.vld_out(sc_v), .cos_o(c1), .sin_o()
	);
	hsr_sincos #(.STAGES(CORDIC_STAGES)) u_sc_lat2 (
		.clk(clk), .arst_n(arst_n), .vld_in(v_s1), .ang(ang2_s1),
		.vld_out(), .cos_o(c2), .sin_o()
	);
	hsr_sincos #(.STAGES(CORDIC_STAGES)) u_sc_dlat (
		.clk(clk), .arst_n(arst_n), .vld_in(v_s1), .ang(ang3_s1),
		.vld_out(), .cos_o(), .sin_o(sd)
	);
	hsr_sincos #(.STAGES(CORDIC_STAGES)) u_sc_dlon (
		.clk(clk), .arst_n(arst_n), .vld_in(v_s1), .ang(ang4_s1),
		.vld_out(), .cos_o(), .sin_o(sl)
	);

	// Magnitudes of the clamped trig values, all within 2^30.
	assign c1m   = 31'((c1 < 0) ? -c1 : c1);
	assign c2m   = 31'((c2 < 0) ? -c2 : c2);
	assign sdm   = 31'((sd < 0) ? -sd : sd);
	assign slm   = 31'((sl < 0) ? -sl : sl);
	assign pfull = 62'(c1m) * 62'(c2m);

	// Stages 2-5: a = s1^2 + sign(p) * floor(|p| * s2^2 / 2^30).
	always_ff @(posedge clk) begin
		pq_s2   <= pfull[60:30];
		pneg_s2 <= c1[hsr_pkg::TRIG_W-1] ^ c2[hsr_pkg::TRIG_W-1];
		s1sq_s2 <= 61'(62'(sdm) * 62'(sdm));
		slm_s2  <= slm;

		u_s3    <= 61'(62'(pq_s2) * 62'(slm_s2));
		s1sq_s3 <= s1sq_s2;
		pneg_s3 <= pneg_s2;
		slm_s3  <= slm_s2;

		uh_s4   <= 61'(61'(u_s3[60:31]) * 61'(slm_s3));
		ul_s4   <= 62'(u_s3[30:0]) * 62'(slm_s3);
		s1sq_s4 <= s1sq_s3;
		pneg_s4 <= pneg_s3;

		t_s5    <= 61'(tsum >> 30);
		s1sq_s5 <= s1sq_s4;
		pneg_s5 <= pneg_s4;

		a_s6    <= anext;
	end

	assign tsum = {1'b0, uh_s4, 31'd0} + 93'(ul_s4);

	// Combine, floor at zero, clamp at one.
	always_comb begin
		apos = 62'(s1sq_s5) + 62'(t_s5);
		if (pneg_s5)
			anext = (t_s5 >= s1sq_s5) ? '0 : (s1sq_s5 - t_s5);
		else if (apos > 62'(hsr_pkg::ONE60))
			anext = hsr_pkg::ONE60;
		else
			anext = apos[60:0];
		if (anext > hsr_pkg::ONE60)
			anext = hsr_pkg::ONE60;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else begin
			v_s2 <= sc_v;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
		end
	end

	hsr_isqrt #(.IN_W(61), .OUT_W(HG_BITS)) u_sqrt_h (
		.clk(clk), .arst_n(arst_n), .vld_in(v_s6), .rad(a_s6),
		.vld_out(h_v), .root(h_root)
	);
	hsr_isqrt #(.IN_W(61), .OUT_W(HG_BITS)) u_sqrt_g (
		.clk(clk), .arst_n(arst_n), .vld_in(v_s6), .rad(hsr_pkg::ONE60 - a_s6),
		.vld_out(g_v), .root(g_root)
	);

	// Stage 7 and on: vectoring CORDIC for the half central angle.
	always_ff @(posedge clk) begin
		vx_s[0] <= hsr_pkg::XY_W'(g_root);
		vy_s[0] <= hsr_pkg::XY_W'(h_root);
		vz_s[0] <= '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vv_s[0] <= 1'b0;
		else
			vv_s[0] <= h_v & g_v;
	end

	for (genvar k = 0; k < CORDIC_STAGES; k++) begin : g_vec
		localparam logic signed [hsr_pkg::Z_W-1:0] ATAN_K = hsr_pkg::atan_entry(k);
		logic signed [hsr_pkg::XY_W-1:0] dx;
		logic signed [hsr_pkg::XY_W-1:0] dy;
		assign dx = vy_s[k] >>> k;
		assign dy = vx_s[k] >>> k;
		always_ff @(posedge clk) begin
			if (vy_s[k] < 0) begin
				vx_s[k+1] <= vx_s[k] - dx;
				vy_s[k+1] <= vy_s[k] + dy;
				vz_s[k+1] <= vz_s[k] - ATAN_K;
			end else begin
				vx_s[k+1] <= vx_s[k] + dx;
				vy_s[k+1] <= vy_s[k] - dy;
				vz_s[k+1] <= vz_s[k] + ATAN_K;
			end
		end
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				vv_s[k+1] <= 1'b0;
			else
				vv_s[k+1] <= vv_s[k];
		end
	end

	// Clamp the half angle to [0, pi/2].
	always_comb begin
		if (vz_s[CORDIC_STAGES] < 0)
			zc = '0;
		else if (vz_s[CORDIC_STAGES] > $signed(hsr_pkg::HALF_PI))
			zc = hsr_pkg::HALF_PI[60:0];
		else
			zc = vz_s[CORDIC_STAGES][60:0];
	end

	assign gsum = {gh_s9, 30'd0} + 93'(gl_s9);

	// Stages 8-12: ground = z * 2R / 2^60, then ground^2 + dalt^2.
	always_ff @(posedge clk) begin
		zc_s8      <= zc;
		gh_s9      <= 63'(zc_s8[60:30]) * 63'(hsr_pkg::RANGE_K);
		gl_s9      <= 62'(zc_s8[29:0]) * 62'(hsr_pkg::RANGE_K);
		ground_s10 <= 33'(gsum >> 60);
		gsq_s11    <= 66'(ground_s10) * 66'(ground_s10);
		asq_s11    <= 66'(adiff_d[ADIFF_IDX]) * 66'(adiff_d[ADIFF_IDX]);
		ssum_s12   <= 67'(gsq_s11) + 67'(asq_s11);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s8  <= 1'b0;
			v_s9  <= 1'b0;
			v_s10 <= 1'b0;
			v_s11 <= 1'b0;
			v_s12 <= 1'b0;
		end else begin
			v_s8  <= vv_s[CORDIC_STAGES];
			v_s9  <= v_s8;
			v_s10 <= v_s9;
			v_s11 <= v_s10;
			v_s12 <= v_s11;
		end
	end

	hsr_isqrt #(.IN_W(67), .OUT_W(SL_BITS)) u_sqrt_slant (
		.clk(clk), .arst_n(arst_n), .vld_in(v_s12), .rad(ssum_s12),
		.vld_out(sl_v), .root(sl_root)
	);

	// Saturate to the result width and compare with the limit.
	assign slant_sat = (sl_root > SL_BITS'(hsr_pkg::SLANT_MAX)) ?
		hsr_pkg::SLANT_MAX : sl_root[32:0];

	always_ff @(posedge clk) begin
		slant_range <= slant_sat;
		in_range    <= (slant_sat <= max_range_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			done <= 1'b0;
		else
			done <= sl_v;
	end

endmodule

@@ rtl/hsr_checker.sv @@
// Port-level checker for the slant range block, bound to the top level.
`include "assert_macros.svh"

module hsr_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        start,
	input logic        busy,
	input logic        done,
	input logic [32:0] slant_range,
	input logic        in_range,
	input logic        cfg_we,
	input logic [32:0] cfg_wdata
);

	logic [32:0] limit_q;

	// Track the limit as last written.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			limit_q <= '0;
		else if (cfg_we)
			limit_q <= cfg_wdata;
	end

	`HSR_ASSERT_ALWAYS(a_never_busy, !busy || !start, "block refused a word")
	`HSR_ASSERT_IMPLY(a_in_range, done, in_range == (slant_range <= limit_q), "in_range mismatch")
	`HSR_ASSERT_IMPLY(a_no_sat, done, slant_range != 33'h1_FFFF_FFFF, "slant range hit saturation")

endmodule

bind haversine_slant_range hsr_checker u_hsr_checker (
	.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .done(done),
	.slant_range(slant_range), .in_range(in_range), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
);
